@@ src/comrt_pkg.sv @@
`default_nettype none

package comrt_pkg;

  localparam int TimeW     = 64;
  localparam int NowW      = 63;
  localparam int AluW      = 66;
  localparam int InDataW   = 384;
  localparam int InUserW   = 1;
  localparam int OutDataW  = 136;

  localparam logic CmdSync  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StProc,
    StRt,
    StNet,
    StOffA,
    StOffB,
    StOffC,
    StOffD,
    StWrite,
    StScan,
    StQryA,
    StQryB,
    StDone
  } state_e;

endpackage

`default_nettype wire

@@ src/clock_offset_min_rtt_tracker_unit.sv @@
// Channel  | Direction | tdata (lowest bit up)                           | tuser
// s_axis   | in        | t1 64, t2 64, t3 64, t4 64, frame 64, now 63, 0 | command
// m_axis   | out       | accepted 1, synced 1, offset 64, age 63, 0      | -
//
// A sync request ends with a scan over every filled window entry; a rejected sync
// request and a query end without one.
// Every step goes through the one 66-bit adder, and the scan reads one window entry
// per cycle from the window memory. After reset the window is empty and unsynchronised.
// A finished result waits in the output register, and a new request is taken meanwhile.
`default_nettype none

module clock_offset_min_rtt_tracker_unit
  import comrt_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // client_send_time, host_receive_time, host_send_time, client_receive_time,
  // frame_host_time, client_now, zero pad.
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // command.
  input  wire logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // sample_accepted, is_synchronized, current_offset, age, zero pad.
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  localparam int IdxW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int SumW = CntW + 1;
  localparam logic [SumW-1:0] DepthS = SumW'(WINDOW_DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(WINDOW_DEPTH);

  function automatic logic [IdxW-1:0] wrap_idx(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] step);
    logic [SumW-1:0] s;
    s = SumW'(base) + SumW'(step);
    if (s >= DepthS) begin
      s = s - DepthS;
    end
    return s[IdxW-1:0];
  endfunction

  state_e state_q, state_d;

  logic             cmd_q;
  logic [TimeW-1:0] t1_q, t2_q, t3_q, t4_q, ts_q;
  logic [NowW-1:0]  now_q;
  logic [TimeW-1:0] proc_q, rt_q;
  logic [AluW-1:0]  acc_q;
  logic [NowW-1:0]  age_q;
  logic             accepted_q;
  logic [TimeW-1:0] best_rt_q, best_off_q;
  logic [CntW-1:0]  cnt_q;
  logic             rvalid_q, rfirst_q;
  logic [TimeW-1:0] chosen_q;
  logic             synced_q;
  logic [IdxW-1:0]  oldest_q;
  logic [CntW-1:0]  filled_q;
  logic             out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [TimeW-1:0] mem_rt [WINDOW_DEPTH];
  logic [TimeW-1:0] mem_off [WINDOW_DEPTH];
  logic [TimeW-1:0] rd_rt_q, rd_off_q;

  logic [AluW-1:0]  alu_a, alu_b, alu_res;
  logic             alu_inv, alu_cin, alu_neg;
  logic             in_fire, out_free, stamp_big, scan_last, take, query_skip;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  wr_slot, rd_addr;
  logic [NowW-1:0]  age_clamp;

  assign alu_res = alu_a + (alu_b ^ {AluW{alu_inv}}) + AluW'(alu_cin);
  assign alu_neg = alu_res[AluW-1];

  assign in_fire    = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free   = ~out_valid_q | m_axis_tready_i;
  assign stamp_big  = t1_q[TimeW-1] | t2_q[TimeW-1] | t3_q[TimeW-1] | t4_q[TimeW-1];
  assign scan_last  = (cnt_q == filled_q);
  assign take       = rfirst_q | alu_neg;
  assign query_skip = ts_q[TimeW-1] | ~synced_q;
  assign wr_slot    = (filled_q != DepthC) ? wrap_idx(oldest_q, filled_q) : oldest_q;
  assign rd_addr    = wrap_idx(oldest_q, cnt_q);

  always_comb begin
    if (alu_neg || (alu_res == '0)) begin
      age_clamp = '0;
    end else if (alu_res[AluW-2:NowW] != '0) begin
      age_clamp = '1;
    end else begin
      age_clamp = alu_res[NowW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = (s_axis_tuser_i[0] == CmdQuery) ? StQryA : StProc;
        end
      end
      StProc:  state_d = alu_neg ? StDone : StRt;
      StRt:    state_d = alu_neg ? StDone : StNet;
      StNet:   state_d = (alu_neg || stamp_big) ? StDone : StOffA;
      StOffA:  state_d = StOffB;
      StOffB:  state_d = StOffC;
      StOffC:  state_d = StOffD;
      StOffD:  state_d = StWrite;
      StWrite: state_d = StScan;
      StScan:  state_d = scan_last ? StDone : StScan;
      StQryA:  state_d = query_skip ? StDone : StQryB;
      StQryB:  state_d = StDone;
      StDone:  state_d = out_free ? StIdle : StDone;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    alu_a           = '0;
    alu_b           = '0;
    alu_inv         = 1'b0;
    alu_cin         = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      StIdle: s_axis_tready_o = 1'b1;
      StProc: begin
        alu_a   = {2'b00, t3_q};
        alu_b   = {2'b00, t2_q};
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      StRt: begin
        alu_a   = {2'b00, t4_q};
        alu_b   = {2'b00, t1_q};
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      StNet: begin
        alu_a   = {2'b00, rt_q};
        alu_b   = {2'b00, proc_q};
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      StOffA: begin
        alu_a = {2'b00, t2_q};
        alu_b = {2'b00, t3_q};
      end
      StOffB: begin
        alu_a   = acc_q;
        alu_b   = {2'b00, t1_q};
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      StOffC: begin
        alu_a   = acc_q;
        alu_b   = {2'b00, t4_q};
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      StOffD: begin
        alu_a   = acc_q;
        alu_cin = acc_q[AluW-1];
      end
      StWrite: mem_we = 1'b1;
      StScan: begin
        alu_a   = {2'b00, rd_rt_q};
        alu_b   = {2'b00, best_rt_q};
        alu_inv = 1'b1;
        alu_cin = 1'b1;
        mem_re  = ~scan_last;
      end
      StQryA: begin
        alu_a = {3'b000, now_q};
        alu_b = {{2{chosen_q[TimeW-1]}}, chosen_q};
      end
      StQryB: begin
        alu_a   = acc_q;
        alu_b   = {2'b00, ts_q};
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      StDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      oldest_q    <= '0;
      filled_q    <= '0;
      chosen_q    <= '0;
      synced_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      rvalid_q    <= 1'b0;
      rfirst_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StWrite) begin
        if (filled_q != DepthC) begin
          filled_q <= filled_q + CntW'(1);
        end else begin
          oldest_q <= wrap_idx(oldest_q, CntW'(1));
        end
        cnt_q    <= '0;
        rvalid_q <= 1'b0;
        rfirst_q <= 1'b0;
      end
      if (state_q == StScan) begin
        rvalid_q <= ~scan_last;
        rfirst_q <= ~scan_last && (cnt_q == '0);
        if (!scan_last) begin
          cnt_q <= cnt_q + CntW'(1);
        end else begin
          chosen_q <= take ? rd_off_q : best_off_q;
          synced_q <= 1'b1;
        end
      end
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= s_axis_tuser_i[0];
      t1_q       <= s_axis_tdata_i[63:0];
      t2_q       <= s_axis_tdata_i[127:64];
      t3_q       <= s_axis_tdata_i[191:128];
      t4_q       <= s_axis_tdata_i[255:192];
      ts_q       <= s_axis_tdata_i[319:256];
      now_q      <= s_axis_tdata_i[382:320];
      age_q      <= '0;
      accepted_q <= 1'b0;
    end
    case (state_q)
      StProc: proc_q <= alu_res[TimeW-1:0];
      StRt:   rt_q   <= alu_res[TimeW-1:0];
      StNet:  rt_q   <= alu_res[TimeW-1:0];
      StOffA, StOffB, StOffC, StOffD: acc_q <= alu_res;
      StScan: begin
        if (rvalid_q && take) begin
          best_rt_q  <= rd_rt_q;
          best_off_q <= rd_off_q;
        end
        if (scan_last) begin
          accepted_q <= (cmd_q == CmdSync);
        end
      end
      StQryA: acc_q <= alu_res;
      StQryB: age_q <= age_clamp;
      default: ;
    endcase
    if ((state_q == StDone) && out_free) begin
      out_data_q <= {7'b0, age_q, chosen_q, synced_q, accepted_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_rt[wr_slot]  <= rt_q;
      mem_off[wr_slot] <= acc_q[TimeW:1];
    end
    if (mem_re) begin
      rd_rt_q  <= mem_rt[rd_addr];
      rd_off_q <= mem_off[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import comrt_pkg::*;

  localparam int          WindowDepth = 8;
  localparam int          IdlePct     = 27;
  localparam int          StallLimit  = 3000;
  localparam int          RandomItems = 750;
  localparam logic [63:0] StampMax    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] StampTop    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] StampHalf   = 64'h8000_0000_0000_0000;

  class offset_tracker_ref;
    typedef struct packed {
      logic        accepted;
      logic        synced;
      logic [63:0] offset;
      logic [62:0] age;
    } outcome_t;

    logic [63:0] window_net[$];
    logic [63:0] window_off[$];
    logic [63:0] chosen_off;
    logic        synced;
    outcome_t    due[$];
    int          mismatches;

    function new();
      chosen_off = '0;
      synced     = 1'b0;
      mismatches = 0;
    endfunction

    function bit idle();
      return due.size() == 0;
    endfunction

    function void take_request(input logic cmd, input logic [63:0] t1, t2, t3, t4, frame,
                               input logic [62:0] now);
      outcome_t           res;
      logic [63:0]        net;
      logic signed [65:0] sum;
      logic signed [65:0] age_full;
      int                 best;
      res.accepted = 1'b0;
      res.age      = '0;
      if (cmd == CmdSync) begin
        if (t3 >= t2 && t4 >= t1 && t4 - t1 >= t3 - t2 &&
            t1 <= StampMax && t2 <= StampMax && t3 <= StampMax && t4 <= StampMax) begin
          net = (t4 - t1) - (t3 - t2);
          sum = $signed({2'b00, t2}) - $signed({2'b00, t1})
              + $signed({2'b00, t3}) - $signed({2'b00, t4});
          sum = sum / 66'sd2;
          window_net = {window_net, net};
          window_off = {window_off, sum[63:0]};
          if (window_net.size() > WindowDepth) begin
            window_net.delete(0);
            window_off.delete(0);
          end
          // Strict comparison keeps the oldest entry when round trips tie.
          best = 0;
          for (int i = 1; i < window_net.size(); i++) begin
            if (window_net[i] < window_net[best]) best = i;
          end
          chosen_off   = window_off[best];
          synced       = 1'b1;
          res.accepted = 1'b1;
        end
      end else if (frame <= StampMax && synced) begin
        age_full = $signed({3'b000, now}) + $signed({{2{chosen_off[63]}}, chosen_off})
                 - $signed({2'b00, frame});
        if (age_full <= 0) res.age = '0;
        else if (age_full > $signed({2'b00, StampMax})) res.age = StampMax[62:0];
        else res.age = age_full[62:0];
      end
      res.synced = synced;
      res.offset = chosen_off;
      due = {due, res};
    endfunction

    function void check_result(input logic [OutDataW-1:0] d);
      outcome_t want;
      outcome_t got;
      got.accepted = d[0];
      got.synced   = d[1];
      got.offset   = d[65:2];
      got.age      = d[128:66];
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding: %h", d);
        return;
      end
      want = due[0];
      due.delete(0);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch (expected/actual): accepted %0b/%0b synced %0b/%0b",
                   want.accepted, got.accepted, want.synced, got.synced);
          $display("  offset %0d/%0d age %0d/%0d", $signed(want.offset),
                   $signed(got.offset), want.age, got.age);
        end
      end
    endfunction
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [InUserW-1:0]  s_axis_tuser_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  bit                  calm  = 1'b0;
  int                  quiet = 0;
  offset_tracker_ref   tracker = new();

  clock_offset_min_rtt_tracker_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99, 0) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) tracker.check_result(m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("[clock_offset_min_rtt_tracker_unit] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_stamp();
    return rand64() >> 1;
  endfunction

  task automatic send_request(input logic cmd, input logic [63:0] t1, t2, t3, t4, frame,
                              input logic [62:0] now);
    while (!calm && $urandom_range(99, 0) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {1'b0, now, frame, t4, t3, t2, t1};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tracker.take_request(cmd, t1, t2, t3, t4, frame, now);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (!tracker.idle()) @(negedge clk_i);
  endtask

  task automatic send_random_sync(input bit broken);
    logic [63:0]        rt;
    logic [63:0]        proc;
    logic [63:0]        t1;
    logic [63:0]        t2;
    logic [63:0]        t3;
    logic [63:0]        t4;
    logic [63:0]        swap;
    logic signed [65:0] host;
    int                 skew;
    if ($urandom_range(99, 0) < 70) rt = 64'($urandom_range(64, 0));
    else rt = rand64() & 64'h0000_00FF_FFFF_FFFF;
    proc = rt - (rand64() % (rt + 64'd1));
    t1 = rand_stamp();
    if ($urandom_range(3, 0) == 0) t1 = t1 & 64'hFFFF_FFFF;
    if (t1 > StampMax - rt) t1 = StampMax - rt;
    t4 = t1 + rt;
    if ($urandom_range(1, 0) == 1) begin
      skew = $urandom_range(2000000, 0) - 1000000;
      host = $signed({2'b00, t1}) + 66'(skew);
    end else begin
      host = $signed({2'b00, rand_stamp()});
    end
    if (host < 0) host = 0;
    if (host > $signed({2'b00, StampMax - proc})) host = $signed({2'b00, StampMax - proc});
    t2 = host[63:0];
    t3 = t2 + proc;
    if (broken) begin
      case ($urandom_range(3, 0))
        0: begin
          swap = t2;
          t2   = t3;
          t3   = swap;
        end
        1: begin
          swap = t1;
          t1   = t4;
          t4   = swap;
        end
        2: t3 = t2 + rt + 64'd1 + 64'($urandom_range(50, 0));
        default: begin
          case ($urandom_range(3, 0))
            0:       t1[63] = 1'b1;
            1:       t2[63] = 1'b1;
            2:       t3[63] = 1'b1;
            default: t4[63] = 1'b1;
          endcase
        end
      endcase
    end
    send_request(CmdSync, t1, t2, t3, t4, rand64(), 63'(rand64()));
  endtask

  task automatic send_age_query();
    logic [63:0]        now;
    logic [63:0]        off;
    logic signed [65:0] stamp;
    int                 lag;
    now = rand_stamp();
    if ($urandom_range(3, 0) == 0) now = now & 64'hFFFF_FFFF;
    off = tracker.chosen_off;
    lag = $urandom_range(1001000, 0) - 1000;
    stamp = $signed({2'b00, now}) + $signed({{2{off[63]}}, off}) - 66'(lag);
    if ($urandom_range(9, 0) == 0) stamp = stamp - $signed({2'b00, rand_stamp() >> 16});
    if (stamp < 0) stamp = 0;
    if (stamp > $signed({2'b00, StampMax})) stamp = $signed({2'b00, StampMax});
    send_request(CmdQuery, rand64(), rand64(), rand64(), rand64(), stamp[63:0], now[62:0]);
  endtask

  initial begin
    int pick;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(CmdQuery, 0, 0, 0, 0, 5, 100);
    send_request(CmdSync, 10, 20, 19, 30, 0, 0);
    send_request(CmdSync, 10, 20, 21, 9, 0, 0);
    send_request(CmdSync, 10, 20, 40, 15, 0, 0);
    send_request(CmdSync, StampHalf, 100, 100, StampTop, 0, 0);
    send_request(CmdSync, 0, StampHalf, StampHalf + 64'd5, 100, 0, 0);
    send_request(CmdSync, StampTop, StampTop, StampTop, StampTop, StampTop, '1);
    send_request(CmdQuery, 0, 0, 0, 0, StampTop, '1);
    send_request(CmdSync, 0, 0, 0, 3, 0, 0);
    send_request(CmdSync, 0, 0, 1, 2, 0, 0);
    send_request(CmdSync, 0, StampMax, StampMax, 0, 0, 0);
    send_request(CmdQuery, 0, 0, 0, 0, 0, StampMax[62:0]);
    send_request(CmdQuery, 0, 0, 0, 0, StampMax, 0);
    send_request(CmdQuery, 0, 0, 0, 0, StampMax, 5);
    send_request(CmdQuery, 0, 0, 0, 0, StampHalf, 5);
    send_request(CmdSync, StampMax, 0, 0, StampMax, 0, 0);
    send_request(CmdSync, 100, 300, 300, 100, 0, 0);
    send_request(CmdQuery, 0, 0, 0, 0, 0, 0);
    send_request(CmdQuery, StampTop, StampTop, StampTop, StampTop, StampMax, 0);
    drain_results();

    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 200) drain_results();
      pick = $urandom_range(99, 0);
      if (pick < 50) send_random_sync(1'b0);
      else if (pick < 60) send_random_sync(1'b1);
      else if (pick < 88) send_age_query();
      else send_request(1'($urandom_range(1, 0)), rand64(), rand64(), rand64(), rand64(),
                        rand64(), 63'(rand64()));
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    while (!tracker.idle()) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.idle()) begin
      $display("[clock_offset_min_rtt_tracker_unit] OK");
    end else begin
      $display("[clock_offset_min_rtt_tracker_unit] ERROR");
    end
    $finish;
  end

endmodule
